/* rtl/cpe_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpe_pkg
// Shared types and constants of the clamped polynomial evaluator.
// ----------------------------------------------------------------------------
package cpe_pkg;

	localparam int DATA_WIDTH       = 32;
	localparam int PROD_W           = 2 * DATA_WIDTH;
	localparam int COUNT_W          = 4;
	localparam int INDEX_W          = 3;
	localparam int CFG_INDEX_W      = 3;
	localparam int MAX_COEFFS_DEF   = 8;
	localparam int FRAC_BITS_DEF    = 16;

	localparam logic signed [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam logic signed [PROD_W-1:0]     PROD_MAX = PROD_W'(DATA_MAX);
	localparam logic signed [PROD_W-1:0]     PROD_MIN = PROD_W'(DATA_MIN);

	typedef enum logic {
		CMD_EVAL  = 1'b0,
		CMD_WRITE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		REGION_IN    = 2'd0,
		REGION_BELOW = 2'd1,
		REGION_ABOVE = 2'd2,
		REGION_EMPTY = 2'd3
	} region_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_COEFF_COUNT     = 3'd0,
		CFG_RANGE_MIN       = 3'd1,
		CFG_RANGE_MAX       = 3'd2,
		CFG_UNDERFLOW_VALUE = 3'd3,
		CFG_OVERFLOW_VALUE  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		cmd_t                          command;
		logic [INDEX_W-1:0]            coeff_index;
		logic signed [DATA_WIDTH-1:0]  coeff_value;
		logic signed [DATA_WIDTH-1:0]  argument;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0]  value;
		region_t                       region;
		logic                          saturated;
	} res_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0]            coeff_count;
		logic signed [DATA_WIDTH-1:0]  range_min;
		logic signed [DATA_WIDTH-1:0]  range_max;
		logic signed [DATA_WIDTH-1:0]  underflow_value;
		logic signed [DATA_WIDTH-1:0]  overflow_value;
	} cfg_t;

	typedef struct packed {
		logic                          write;
		logic [INDEX_W-1:0]            index;
		logic signed [DATA_WIDTH-1:0]  wdata;
		logic signed [DATA_WIDTH-1:0]  x;
		logic signed [DATA_WIDTH-1:0]  acc;
		logic [COUNT_W-1:0]            steps;
		region_t                       region;
		logic                          sat;
	} pipe_t;

endpackage
`default_nettype wire

/* rtl/cpe_entry.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpe_entry
// Coefficient table, range classification and first pipeline stage.
// ----------------------------------------------------------------------------
module cpe_entry #(
	parameter int MAX_COEFFS = cpe_pkg::MAX_COEFFS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire cpe_pkg::in_item_t item,
	input  wire cpe_pkg::cfg_t    cfg,
	output logic                  out_valid,
	output cpe_pkg::pipe_t        out_pipe
);

	localparam int IW = $clog2(MAX_COEFFS);

	logic signed [cpe_pkg::DATA_WIDTH-1:0] coeff_q [MAX_COEFFS];
	logic [cpe_pkg::COUNT_W-1:0]           n_eff;
	logic                                  wr_en;
	cpe_pkg::pipe_t                        pipe_d;
	logic                                  valid_s1;
	cpe_pkg::pipe_t                        pipe_s1;

	assign wr_en = accept && (item.command == cpe_pkg::CMD_WRITE)
		&& (32'(item.coeff_index) < MAX_COEFFS);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			coeff_q[IW'(item.coeff_index)] <= item.coeff_value;
		end
	end

	always_comb begin
		if (32'(cfg.coeff_count) > MAX_COEFFS) begin
			n_eff = cpe_pkg::COUNT_W'(MAX_COEFFS);
		end else begin
			n_eff = cfg.coeff_count;
		end
		pipe_d.write = (item.command == cpe_pkg::CMD_WRITE);
		pipe_d.index = item.coeff_index;
		pipe_d.wdata = item.coeff_value;
		pipe_d.x     = item.argument;
		pipe_d.sat   = 1'b0;
		pipe_d.steps = '0;
		if (n_eff == '0) begin
			pipe_d.region = cpe_pkg::REGION_EMPTY;
			pipe_d.acc    = '0;
		end else if (item.argument < cfg.range_min) begin
			pipe_d.region = cpe_pkg::REGION_BELOW;
			pipe_d.acc    = cfg.underflow_value;
		end else if (item.argument > cfg.range_max) begin
			pipe_d.region = cpe_pkg::REGION_ABOVE;
			pipe_d.acc    = cfg.overflow_value;
		end else begin
			pipe_d.region = cpe_pkg::REGION_IN;
			pipe_d.acc    = coeff_q[IW'(n_eff - 1'b1)];
			pipe_d.steps  = n_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pipe_s1 <= pipe_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_pipe  = pipe_s1;

endmodule
`default_nettype wire

/* rtl/cpe_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpe_step
// One Horner step: registered multiply, then floor, saturate and add.
// ----------------------------------------------------------------------------
module cpe_step #(
	parameter int STEP      = 1,
	parameter int FRAC_BITS = cpe_pkg::FRAC_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire cpe_pkg::pipe_t   in_pipe,
	output logic                  out_valid,
	output cpe_pkg::pipe_t        out_pipe
);

	localparam int DW = cpe_pkg::DATA_WIDTH;
	localparam int PW = cpe_pkg::PROD_W;

	logic signed [DW-1:0] coeff_q;
	logic                 valid_s1;
	cpe_pkg::pipe_t       pipe_s1;
	logic signed [PW-1:0] prod_s1;
	logic                 valid_s2;
	cpe_pkg::pipe_t       pipe_s2;
	logic signed [PW-1:0] q;
	logic signed [DW-1:0] q_c;
	logic signed [DW:0]   sum;
	logic signed [DW-1:0] acc_new;
	logic                 sat_new;
	logic                 active;
	cpe_pkg::pipe_t       pipe_d;

	// this step adds coefficient STEP-1
	always_ff @(posedge clk) begin
		if (in_valid && in_pipe.write && (32'(in_pipe.index) == STEP - 1)) begin
			coeff_q <= in_pipe.wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		pipe_s1 <= in_pipe;
		prod_s1 <= PW'(in_pipe.acc) * PW'(in_pipe.x);
		pipe_s2 <= pipe_d;
	end

	always_comb begin
		q       = prod_s1 >>> FRAC_BITS;
		sat_new = 1'b0;
		if (q > cpe_pkg::PROD_MAX) begin
			q_c     = cpe_pkg::DATA_MAX;
			sat_new = 1'b1;
		end else if (q < cpe_pkg::PROD_MIN) begin
			q_c     = cpe_pkg::DATA_MIN;
			sat_new = 1'b1;
		end else begin
			q_c = DW'(q);
		end
		sum = {q_c[DW-1], q_c} + {coeff_q[DW-1], coeff_q};
		if (sum[DW] != sum[DW-1]) begin
			acc_new = sum[DW] ? cpe_pkg::DATA_MIN : cpe_pkg::DATA_MAX;
			sat_new = 1'b1;
		end else begin
			acc_new = sum[DW-1:0];
		end
		active = (32'(pipe_s1.steps) > STEP);
		pipe_d = pipe_s1;
		if (active) begin
			pipe_d.acc = acc_new;
			pipe_d.sat = pipe_s1.sat | sat_new;
		end
	end

	assign out_valid = valid_s2;
	assign out_pipe  = pipe_s2;

endmodule
`default_nettype wire

/* rtl/clamped_polynomial_evaluator_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// clamped_polynomial_evaluator_core
// Throughput: one transaction per cycle; each Horner step owns a multiplier
// followed by a floor/saturate/add stage, so busy stays low.
// Coefficient writes flow through the pipeline in order and give no result.
// Reset returns the config registers to their defaults and clears the valid bits, not the coefficients.
// ----------------------------------------------------------------------------
module clamped_polynomial_evaluator_core #(
	parameter int MAX_COEFFS = cpe_pkg::MAX_COEFFS_DEF,
	parameter int FRAC_BITS  = cpe_pkg::FRAC_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire cpe_pkg::in_item_t                 item,
	output logic                                   done,
	output cpe_pkg::res_item_t                     result,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [cpe_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [cpe_pkg::DATA_WIDTH-1:0]    cfg_data
);

	localparam int LAT = 2 * MAX_COEFFS - 1;

	cpe_pkg::cfg_t  cfg_q;
	logic           accept;
	logic           chain_valid [MAX_COEFFS];
	cpe_pkg::pipe_t chain_pipe  [MAX_COEFFS];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coeff_count     <= '0;
			cfg_q.range_min       <= cpe_pkg::DATA_MIN;
			cfg_q.range_max       <= cpe_pkg::DATA_MAX;
			cfg_q.underflow_value <= '0;
			cfg_q.overflow_value  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cpe_pkg::CFG_COEFF_COUNT: begin
					cfg_q.coeff_count <= cfg_data[cpe_pkg::COUNT_W-1:0];
				end
				cpe_pkg::CFG_RANGE_MIN: begin
					cfg_q.range_min <= cfg_data;
				end
				cpe_pkg::CFG_RANGE_MAX: begin
					cfg_q.range_max <= cfg_data;
				end
				cpe_pkg::CFG_UNDERFLOW_VALUE: begin
					cfg_q.underflow_value <= cfg_data;
				end
				cpe_pkg::CFG_OVERFLOW_VALUE: begin
					cfg_q.overflow_value <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	cpe_entry #(
		.MAX_COEFFS (MAX_COEFFS)
	) u_entry (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.cfg       (cfg_q),
		.out_valid (chain_valid[0]),
		.out_pipe  (chain_pipe[0])
	);

	// highest power first, coefficient zero added last
	for (genvar g = 0; g < MAX_COEFFS - 1; g++) begin : g_step
		cpe_step #(
			.STEP      (MAX_COEFFS - 1 - g),
			.FRAC_BITS (FRAC_BITS)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[g]),
			.in_pipe   (chain_pipe[g]),
			.out_valid (chain_valid[g+1]),
			.out_pipe  (chain_pipe[g+1])
		);
	end

	assign done             = chain_valid[MAX_COEFFS-1] && !chain_pipe[MAX_COEFFS-1].write;
	assign result.value     = chain_pipe[MAX_COEFFS-1].acc;
	assign result.region    = chain_pipe[MAX_COEFFS-1].region;
	assign result.saturated = chain_pipe[MAX_COEFFS-1].sat;

`ifndef SYNTH
	a_done_from_eval: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept && (item.command == cpe_pkg::CMD_EVAL), LAT))
		else $error("result without matching evaluate transaction");

	a_clamp_not_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.region != cpe_pkg::REGION_IN) |-> !result.saturated)
		else $error("saturation flagged on clamp or empty result");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.region == cpe_pkg::REGION_EMPTY) |-> (result.value == '0))
		else $error("empty polynomial result is not zero");

	a_below_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.region == cpe_pkg::REGION_BELOW)
		|-> (result.value == cfg_q.underflow_value))
		else $error("underflow result does not match configured value");
`endif

endmodule
`default_nettype wire

/* dv/clamped_polynomial_evaluator_core_test.sv */
// ----------------------------------------------------------------------------
// clamped_polynomial_evaluator_core_test
// Self-checking bench for the clamped polynomial evaluator. A clocked driver
// sends coefficient writes and evaluations from a queue, with random gaps. A
// Horner predictor with 64-bit intermediates models the block and keeps its
// own coefficient table and register copy. A monitor checks each result
// against the oldest prediction. The run steps through several register
// settings, the extremes among them, and writes them only while the block is
// idle.
// ----------------------------------------------------------------------------
module clamped_polynomial_evaluator_core_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_TERMS       = cpe_pkg::MAX_COEFFS_DEF;
	localparam int FRAC            = cpe_pkg::FRAC_BITS_DEF;
	localparam int LATENCY         = 2 * MAX_TERMS - 1;
	localparam int SETTLE_CYCLES   = LATENCY + 8;
	localparam int IDLE_LIMIT      = 2000;
	localparam int NUM_PHASES      = 10;
	localparam int ITEMS_PER_PHASE = 118;

	localparam logic [cpe_pkg::CFG_INDEX_W-1:0]      CFG_UNUSED = 3'd7;
	localparam logic signed [cpe_pkg::DATA_WIDTH-1:0] Q_ONE     = 1 << FRAC;

	logic                                   clk;
	logic                                   arst_n = 1'b0;
	logic                                   start = 1'b0;
	logic                                   busy;
	cpe_pkg::in_item_t                      cmd_item = '0;
	logic                                   done;
	cpe_pkg::res_item_t                     result;
	logic                                   cfg_valid = 1'b0;
	logic                                   cfg_ready;
	logic [cpe_pkg::CFG_INDEX_W-1:0]        cfg_index = '0;
	logic [cpe_pkg::DATA_WIDTH-1:0]         cfg_data = '0;

	cpe_pkg::in_item_t                      cmd_queue[$];
	cpe_pkg::res_item_t                     predicted_results[$];
	logic signed [cpe_pkg::DATA_WIDTH-1:0]  coeff_shadow[MAX_TERMS];
	cpe_pkg::cfg_t                          cfg_shadow;

	int gap_left;
	bit steady;
	int errors;
	int idle_cycles;
	int n_writes;
	int n_evals;
	int n_results;
	int n_settings;
	int n_saturated;
	int region_hits[4];

	clamped_polynomial_evaluator_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (cmd_item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint clip(longint v, inout logic hit);
		if (v > longint'(cpe_pkg::DATA_MAX)) begin
			hit = 1'b1;
			return cpe_pkg::DATA_MAX;
		end
		if (v < longint'(cpe_pkg::DATA_MIN)) begin
			hit = 1'b1;
			return cpe_pkg::DATA_MIN;
		end
		return v;
	endfunction

	function automatic cpe_pkg::res_item_t poly_predict(
		logic signed [cpe_pkg::DATA_WIDTH-1:0] x);
		cpe_pkg::res_item_t r;
		int                 n;
		longint             acc;
		logic               hit;
		hit = 1'b0;
		r.value = '0;
		r.region = cpe_pkg::REGION_IN;
		n = (cfg_shadow.coeff_count > MAX_TERMS) ? MAX_TERMS : int'(cfg_shadow.coeff_count);
		if (n == 0) begin
			r.region = cpe_pkg::REGION_EMPTY;
		end else if (x < cfg_shadow.range_min) begin
			r.region = cpe_pkg::REGION_BELOW;
			r.value = cfg_shadow.underflow_value;
		end else if (x > cfg_shadow.range_max) begin
			r.region = cpe_pkg::REGION_ABOVE;
			r.value = cfg_shadow.overflow_value;
		end else begin
			acc = coeff_shadow[n-1];
			for (int i = n - 2; i >= 0; i--) begin
				acc = clip((acc * longint'(x)) >>> FRAC, hit);
				acc = clip(acc + coeff_shadow[i], hit);
			end
			r.value = acc[cpe_pkg::DATA_WIDTH-1:0];
		end
		r.saturated = hit;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				if (cmd_item.command == cpe_pkg::CMD_WRITE) begin
					coeff_shadow[cmd_item.coeff_index] = cmd_item.coeff_value;
					n_writes++;
				end else begin
					predicted_results.push_back(poly_predict(cmd_item.argument));
					n_evals++;
				end
			end
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (cmd_queue.size() != 0) begin
					cmd_item <= cmd_queue.pop_front();
					start <= 1'b1;
					gap_left = pick_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		cpe_pkg::res_item_t want;
		if (arst_n && done) begin
			n_results++;
			if (predicted_results.size() == 0) begin
				$error("result with no evaluation pending: value %0d", result.value);
				errors++;
			end else begin
				want = predicted_results.pop_front();
				region_hits[want.region]++;
				if (want.saturated)
					n_saturated++;
				if (result.value !== want.value) begin
					$error("value: expected %0d, got %0d", want.value, result.value);
					errors++;
				end
				if (result.region !== want.region) begin
					$error("region: expected %0d, got %0d", want.region, result.region);
					errors++;
				end
				if (result.saturated !== want.saturated) begin
					$error("saturated: expected %0d, got %0d", want.saturated,
						result.saturated);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
			$display("** clamped_polynomial_evaluator_core: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic write_cfg(logic [cpe_pkg::CFG_INDEX_W-1:0] idx,
		logic [cpe_pkg::DATA_WIDTH-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			cpe_pkg::CFG_COEFF_COUNT:
				cfg_shadow.coeff_count = data[cpe_pkg::COUNT_W-1:0];
			cpe_pkg::CFG_RANGE_MIN:       cfg_shadow.range_min = data;
			cpe_pkg::CFG_RANGE_MAX:       cfg_shadow.range_max = data;
			cpe_pkg::CFG_UNDERFLOW_VALUE: cfg_shadow.underflow_value = data;
			cpe_pkg::CFG_OVERFLOW_VALUE:  cfg_shadow.overflow_value = data;
			default: ;
		endcase
	endtask

	task automatic apply_config(cpe_pkg::cfg_t c);
		write_cfg(cpe_pkg::CFG_COEFF_COUNT, cpe_pkg::DATA_WIDTH'(c.coeff_count));
		write_cfg(cpe_pkg::CFG_RANGE_MIN, c.range_min);
		write_cfg(cpe_pkg::CFG_RANGE_MAX, c.range_max);
		write_cfg(cpe_pkg::CFG_UNDERFLOW_VALUE, c.underflow_value);
		write_cfg(cpe_pkg::CFG_OVERFLOW_VALUE, c.overflow_value);
		n_settings++;
		@(negedge clk);
	endtask

	task automatic drain();
		do @(negedge clk);
		while (cmd_queue.size() != 0 || start || predicted_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_write(int idx, logic signed [cpe_pkg::DATA_WIDTH-1:0] val);
		cpe_pkg::in_item_t it;
		it.command = cpe_pkg::CMD_WRITE;
		it.coeff_index = cpe_pkg::INDEX_W'(idx);
		it.coeff_value = val;
		it.argument = $urandom;
		cmd_queue.push_back(it);
	endtask

	task automatic push_eval(logic signed [cpe_pkg::DATA_WIDTH-1:0] arg);
		cpe_pkg::in_item_t it;
		it.command = cpe_pkg::CMD_EVAL;
		it.coeff_index = cpe_pkg::INDEX_W'($urandom_range(0, 7));
		it.coeff_value = $urandom;
		it.argument = arg;
		cmd_queue.push_back(it);
	endtask

	function automatic logic signed [cpe_pkg::DATA_WIDTH-1:0] pick_word();
		case ($urandom_range(0, 3))
			0:       return cpe_pkg::DATA_MIN;
			1:       return cpe_pkg::DATA_MAX;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [cpe_pkg::DATA_WIDTH-1:0] pick_coeff();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return int'($urandom_range(0, 1 << 18)) - (1 << 17);
		if (r < 8)
			return $urandom;
		case ($urandom_range(0, 3))
			0:       return cpe_pkg::DATA_MAX;
			1:       return cpe_pkg::DATA_MIN;
			2:       return '0;
			default: return Q_ONE;
		endcase
	endfunction

	function automatic logic signed [cpe_pkg::DATA_WIDTH-1:0] pick_argument();
		int                   r;
		longint               span;
		longint unsigned      draw;
		r = $urandom_range(0, 9);
		if (r < 3)
			return int'($urandom_range(0, 1 << 18)) - (1 << 17);
		if (r < 5 || (r < 8 && cfg_shadow.range_min > cfg_shadow.range_max))
			return $urandom;
		if (r < 8) begin
			span = longint'(cfg_shadow.range_max) - longint'(cfg_shadow.range_min);
			draw = {$urandom, $urandom};
			return cpe_pkg::DATA_WIDTH'(longint'(cfg_shadow.range_min) +
				longint'(draw % longint'(span + 1)));
		end
		case ($urandom_range(0, 6))
			0:       return cfg_shadow.range_min;
			1:       return cfg_shadow.range_max;
			2:       return cfg_shadow.range_min - 1;
			3:       return cfg_shadow.range_max + 1;
			4:       return cpe_pkg::DATA_MIN;
			5:       return cpe_pkg::DATA_MAX;
			default: return '0;
		endcase
	endfunction

	function automatic cpe_pkg::cfg_t pick_config(int ph);
		cpe_pkg::cfg_t                         c;
		int                                    mode;
		logic signed [cpe_pkg::DATA_WIDTH-1:0] a;
		logic signed [cpe_pkg::DATA_WIDTH-1:0] b;
		logic signed [cpe_pkg::DATA_WIDTH-1:0] t;
		case ($urandom_range(0, 5))
			0:       c.coeff_count = 4'd15;
			1:       c.coeff_count = 4'd1;
			2:       c.coeff_count = cpe_pkg::COUNT_W'($urandom_range(9, 15));
			default: c.coeff_count = cpe_pkg::COUNT_W'($urandom_range(1, MAX_TERMS));
		endcase
		if (ph == 0)
			c.coeff_count = 4'd15;
		if (ph == NUM_PHASES - 1)
			c.coeff_count = '0;
		mode = (ph == 1) ? 3 : $urandom_range(0, 4);
		a = $urandom;
		b = $urandom;
		case (mode)
			0: begin
				c.range_min = cpe_pkg::DATA_MIN;
				c.range_max = cpe_pkg::DATA_MAX;
			end
			1: begin
				t = $urandom_range(1, 1 << 19);
				c.range_min = -t;
				c.range_max = t;
			end
			2: begin
				c.range_min = (a < b) ? a : b;
				c.range_max = (a < b) ? b : a;
			end
			3: begin
				c.range_min = $urandom_range(0, 1) ? cpe_pkg::DATA_MAX : ((a < b) ? b : a);
				c.range_max = (c.range_min == cpe_pkg::DATA_MAX) ? cpe_pkg::DATA_MIN
					: ((a < b) ? a : b);
			end
			default: begin
				c.range_min = a;
				c.range_max = b;
			end
		endcase
		c.underflow_value = pick_word();
		c.overflow_value = pick_word();
		return c;
	endfunction

	initial begin
		cfg_shadow = '{coeff_count: '0, range_min: cpe_pkg::DATA_MIN,
			range_max: cpe_pkg::DATA_MAX, underflow_value: '0, overflow_value: '0};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: load the whole table, evaluations give the empty region
		push_write(0, Q_ONE);
		push_write(1, cpe_pkg::DATA_MAX);
		push_write(2, cpe_pkg::DATA_MIN);
		push_write(3, '0);
		push_write(4, -1);
		push_write(5, Q_ONE >>> 1);
		push_write(6, -Q_ONE);
		push_write(7, Q_ONE <<< 1);
		push_eval(cpe_pkg::DATA_MIN);
		push_eval(cpe_pkg::DATA_MAX);
		drain();

		// all eight terms over the full range
		apply_config('{coeff_count: 4'd8, range_min: cpe_pkg::DATA_MIN,
			range_max: cpe_pkg::DATA_MAX, underflow_value: '0, overflow_value: '0});
		push_eval('0);
		push_eval(Q_ONE);
		push_eval(-Q_ONE);
		push_eval(1);
		push_eval(cpe_pkg::DATA_MAX);
		push_eval(cpe_pkg::DATA_MIN);
		push_write(7, cpe_pkg::DATA_MIN);
		push_eval(cpe_pkg::DATA_MAX);
		drain();

		write_cfg(CFG_UNUSED, $urandom);

		// narrow range with extreme clamp values
		apply_config('{coeff_count: 4'd3, range_min: -(Q_ONE <<< 1), range_max: Q_ONE <<< 1,
			underflow_value: cpe_pkg::DATA_MIN, overflow_value: cpe_pkg::DATA_MAX});
		push_eval(-(Q_ONE <<< 1) - 1);
		push_eval(-(Q_ONE <<< 1));
		push_eval(Q_ONE <<< 1);
		push_eval((Q_ONE <<< 1) + 1);
		drain();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			apply_config(pick_config(ph));
			steady = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if ($urandom_range(0, 3) == 0)
					push_write($urandom_range(0, MAX_TERMS - 1), pick_coeff());
				else
					push_eval(pick_argument());
			end
			drain();
		end

		$display("covered %0d evaluations and %0d coefficient writes under %0d settings",
			n_evals, n_writes, n_settings);
		$display("results %0d: in %0d, below %0d, above %0d, empty %0d, saturated %0d",
			n_results, region_hits[cpe_pkg::REGION_IN], region_hits[cpe_pkg::REGION_BELOW],
			region_hits[cpe_pkg::REGION_ABOVE], region_hits[cpe_pkg::REGION_EMPTY],
			n_saturated);
		if (errors == 0)
			$display("** clamped_polynomial_evaluator_core: PASSED **");
		else
			$display("** clamped_polynomial_evaluator_core: FAILED **");
		$finish;
	end

endmodule

/* sim.f */
rtl/cpe_pkg.sv
rtl/cpe_entry.sv
rtl/cpe_step.sv
rtl/clamped_polynomial_evaluator_core.sv
dv/clamped_polynomial_evaluator_core_test.sv
